[sv/cpbe_pkg.sv]
// Shared types and constants of the cassette pulse block encoder.
// Used by every module of the block; depends on nothing else.
package cpbe_pkg;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_DATA   = 2'd1,
        OP_END    = 2'd2,
        OP_UNUSED = 2'd3
    } op_code_t;

    // Command kinds that travel from the front part to the back part.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2
    } cmd_kind_t;

    // A queued command: its kind and a 16-bit word (the byte or the checksum).
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] word;
    } cmd_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_LONG_HIGH  = 3'd0;
    localparam logic [2:0] REG_LONG_LOW   = 3'd1;
    localparam logic [2:0] REG_SHORT_HIGH = 3'd2;
    localparam logic [2:0] REG_SHORT_LOW  = 3'd3;
    localparam logic [2:0] REG_GAP        = 3'd4;
    localparam logic [2:0] REG_MARK_LONG  = 3'd5;
    localparam logic [2:0] REG_MARK_SHORT = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_LONG_HIGH  = 16'd22;
    localparam logic [15:0] RST_LONG_LOW   = 16'd22;
    localparam logic [15:0] RST_SHORT_HIGH = 16'd11;
    localparam logic [15:0] RST_SHORT_LOW  = 16'd11;
    localparam logic [15:0] RST_GAP        = 16'd11000;
    localparam logic [7:0]  RST_MARK_LONG  = 8'd40;
    localparam logic [7:0]  RST_MARK_SHORT = 8'd40;

    // Configuration as seen by the back part.
    typedef struct packed {
        logic [15:0] long_high;
        logic [15:0] long_low;
        logic [15:0] short_high;
        logic [15:0] short_low;
        logic [15:0] gap_pulses;
        logic [7:0]  mark_long;
        logic [7:0]  mark_short;
    } cfg_t;

    // Command queue geometry.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Descriptor sequencing.
    localparam int STEP_W          = 5;
    localparam int BYTE_STEPS      = 9;
    localparam int DATA_STOP_STEP  = 8;
    localparam int END_PAIR_STEP   = 18;
    localparam int START_GAP_STEP  = 0;
    localparam int START_MLONG_STEP = 1;
    localparam int START_MSHORT_STEP = 2;
    localparam logic [15:0] PAIR_COUNT = 16'd2;
    localparam logic [15:0] ONE_PULSE  = 16'd1;

endpackage

[sv/cpbe_cfg_regs.sv]
// Configuration register file of the cassette pulse block encoder.
// Depends on cpbe_pkg for the register indexes, reset values and cfg_t.
module cpbe_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    output cpbe_pkg::cfg_t cfg
);
    import cpbe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write into the addressed register; other indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LONG_HIGH:  cfg_next.long_high  = cfg_data;
                REG_LONG_LOW:   cfg_next.long_low   = cfg_data;
                REG_SHORT_HIGH: cfg_next.short_high = cfg_data;
                REG_SHORT_LOW:  cfg_next.short_low  = cfg_data;
                REG_GAP:        cfg_next.gap_pulses = cfg_data;
                REG_MARK_LONG:  cfg_next.mark_long  = cfg_data[7:0];
                REG_MARK_SHORT: cfg_next.mark_short = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_high  <= RST_LONG_HIGH;
            cfg_reg.long_low   <= RST_LONG_LOW;
            cfg_reg.short_high <= RST_SHORT_HIGH;
            cfg_reg.short_low  <= RST_SHORT_LOW;
            cfg_reg.gap_pulses <= RST_GAP;
            cfg_reg.mark_long  <= RST_MARK_LONG;
            cfg_reg.mark_short <= RST_MARK_SHORT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/cpbe_front.sv]
// Front part: accepts input transactions, classifies them and keeps the checksum.
// Depends on cpbe_pkg for the operation codes and the command type.
module cpbe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     operation,
    input  logic [7:0]     data_byte,
    input  logic           queue_full,
    output logic           cmd_wr,
    output cpbe_pkg::cmd_t cmd
);
    import cpbe_pkg::*;

    logic [15:0] csum_reg;
    logic [15:0] csum_next;
    logic        accept;
    logic [3:0]  ones;
    op_code_t    op;

    assign op     = op_code_t'(operation);
    assign accept = push && !queue_full;
    assign full   = queue_full;

    // Count of one bits in the incoming byte.
    always_comb
    begin
        ones = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            ones = ones + {3'd0, data_byte[i]};
        end
    end

    // Classify the transaction and build the command for the back part.
    always_comb
    begin
        cmd_wr    = 1'b0;
        cmd.kind  = CMD_START;
        cmd.word  = 16'd0;
        csum_next = csum_reg;
        if (accept)
        begin
            case (op)
                OP_START:
                begin
                    cmd_wr    = 1'b1;
                    cmd.kind  = CMD_START;
                    csum_next = 16'd0;
                end
                OP_DATA:
                begin
                    cmd_wr    = 1'b1;
                    cmd.kind  = CMD_DATA;
                    cmd.word  = {8'd0, data_byte};
                    csum_next = csum_reg + {12'd0, ones};
                end
                OP_END:
                begin
                    cmd_wr   = 1'b1;
                    cmd.kind = CMD_END;
                    cmd.word = csum_reg;
                end
                default:
                begin
                    cmd_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_reg <= 16'd0;
        end
        else
        begin
            csum_reg <= csum_next;
        end
    end

endmodule

[sv/cpbe_cmd_fifo.sv]
// Short command queue between the front and the back part.
// Depends on cpbe_pkg for cmd_t and the queue geometry.
module cpbe_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  cpbe_pkg::cmd_t wr_cmd,
    output logic           queue_full,
    input  logic           rd_en,
    output logic           head_valid,
    output cpbe_pkg::cmd_t head_cmd
);
    import cpbe_pkg::*;

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign queue_full = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !queue_full;
    assign do_rd      = rd_en && head_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; only occupied entries are read.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[sv/cpbe_back.sv]
// Back part: expands each queued command into pulse descriptors, one a cycle while results are popped.
// Depends on cpbe_pkg for cmd_t, cfg_t and the sequencing constants.
module cpbe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  cpbe_pkg::cfg_t cfg,
    input  logic           head_valid,
    input  cpbe_pkg::cmd_t head_cmd,
    output logic           head_pop,
    output logic           empty,
    input  logic           pop,
    output logic [15:0]    high_samples,
    output logic [15:0]    low_samples,
    output logic [15:0]    repeat_res,
    output logic           last
);
    import cpbe_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] sub;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [15:0]       high_reg;
    logic [15:0]       low_reg;
    logic [15:0]       rep_reg;
    logic              last_reg;
    logic              take;
    logic              d_long;
    logic [15:0]       d_rep;
    logic              d_last;
    logic [7:0]        cur_byte;
    logic [7:0]        shifted;

    // Pick the byte and the bit position within it for the current step.
    always_comb
    begin
        if (head_cmd.kind == CMD_END && step_reg < STEP_W'(BYTE_STEPS))
        begin
            cur_byte = head_cmd.word[15:8];
            sub      = step_reg;
        end
        else if (head_cmd.kind == CMD_END)
        begin
            cur_byte = head_cmd.word[7:0];
            sub      = step_reg - STEP_W'(BYTE_STEPS);
        end
        else
        begin
            cur_byte = head_cmd.word[7:0];
            sub      = step_reg;
        end
        shifted = cur_byte << sub[2:0];
    end

    // Descriptor for the current command and step.
    always_comb
    begin
        d_long = 1'b1;
        d_rep  = ONE_PULSE;
        d_last = 1'b0;
        case (head_cmd.kind)
            CMD_START:
            begin
                if (step_reg == STEP_W'(START_GAP_STEP))
                begin
                    d_long = 1'b0;
                    d_rep  = cfg.gap_pulses;
                end
                else if (step_reg == STEP_W'(START_MLONG_STEP))
                begin
                    d_rep = {8'd0, cfg.mark_long};
                end
                else if (step_reg == STEP_W'(START_MSHORT_STEP))
                begin
                    d_long = 1'b0;
                    d_rep  = {8'd0, cfg.mark_short};
                end
                else
                begin
                    d_rep  = PAIR_COUNT;
                    d_last = 1'b1;
                end
            end
            CMD_DATA:
            begin
                if (step_reg == STEP_W'(DATA_STOP_STEP))
                begin
                    d_last = 1'b1;
                end
                else
                begin
                    d_long = shifted[7];
                end
            end
            CMD_END:
            begin
                if (step_reg == STEP_W'(END_PAIR_STEP))
                begin
                    d_rep  = PAIR_COUNT;
                    d_last = 1'b1;
                end
                else if (sub != STEP_W'(DATA_STOP_STEP))
                begin
                    d_long = shifted[7];
                end
            end
            default:
            begin
                d_last = 1'b1;
            end
        endcase
    end

    // The output register loads whenever a command is queued and the register is free or being emptied.
    assign take     = head_valid && (!out_valid_reg || pop);
    assign head_pop = take && d_last;

    always_comb
    begin
        step_next = step_reg;
        if (take)
        begin
            step_next = d_last ? '0 : step_reg + 1'b1;
        end
        out_valid_next = take ? 1'b1 : (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            high_reg <= d_long ? cfg.long_high : cfg.short_high;
            low_reg  <= d_long ? cfg.long_low : cfg.short_low;
            rep_reg  <= d_rep;
            last_reg <= d_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign high_samples = high_reg;
    assign low_samples  = low_reg;
    assign repeat_res   = rep_reg;
    assign last         = last_reg;

endmodule

[sv/cassette_pulse_block_encoder_unit.sv]
// Top level of the cassette pulse block encoder.
// Depends on cpbe_pkg, cpbe_cfg_regs, cpbe_front, cpbe_cmd_fifo and cpbe_back.
//
//   Channel   Handshake        Payload
//   input     push / full      operation[1:0], data_byte[7:0]
//   result    empty / pop      high_samples, low_samples, repeat_res, last
//   config    cfg_we           cfg_index[2:0], cfg_data[15:0]
//
// One descriptor leaves the back part per cycle while results are popped: a start
// transaction gives 4 descriptors, a data one 9 and an end one 19, set by the back part's step counter.
// A transaction's first descriptor reaches the result ports via the command queue, then the output register.
// A four-entry command queue lets the front keep taking transactions while the back stalls.
// Reset clears the checksum, the queue, the step counter and the output valid flag and loads the register defaults.
module cassette_pulse_block_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] high_samples,
    output logic [15:0] low_samples,
    output logic [15:0] repeat_res,
    output logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import cpbe_pkg::*;

    cfg_t cfg;
    cmd_t wr_cmd;
    cmd_t head_cmd;
    logic cmd_wr;
    logic queue_full;
    logic head_valid;
    logic head_pop;

    // Configuration registers.
    cpbe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Front part: takes transactions and keeps the checksum.
    cpbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .cmd_wr     (cmd_wr),
        .cmd        (wr_cmd)
    );

    // Command queue.
    cpbe_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cmd_wr),
        .wr_cmd     (wr_cmd),
        .queue_full (queue_full),
        .rd_en      (head_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back part: descriptor sequencer and output register.
    cpbe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .head_pop     (head_pop),
        .empty        (empty),
        .pop          (pop),
        .high_samples (high_samples),
        .low_samples  (low_samples),
        .repeat_res   (repeat_res),
        .last         (last)
    );

endmodule

[tb/cassette_pulse_block_encoder_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cassette_pulse_block_encoder_unit.
// Depends on cpbe_pkg and the encoder RTL; a built-in pulse predictor checks every descriptor.
module cassette_pulse_block_encoder_unit_tb;

    import cpbe_pkg::*;

    localparam int IDLE_PCT      = 31;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam logic [2:0] REG_NONE = 3'd7;

    // One input transaction waiting to be sent.
    typedef struct {
        op_code_t    op;
        logic [7:0]  data_val;
        bit          drain;
    } tape_item_t;

    // One expected pulse descriptor.
    typedef struct {
        logic [15:0] high_s;
        logic [15:0] low_s;
        logic [15:0] rep;
        logic        last_flag;
    } pulse_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    logic [1:0]  operation = OP_START;
    logic [7:0]  data_byte = 8'h00;
    logic        empty;
    logic        pop       = 1'b0;
    logic [15:0] high_samples;
    logic [15:0] low_samples;
    logic [15:0] repeat_res;
    logic        last;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = REG_LONG_HIGH;
    logic [15:0] cfg_data  = 16'h0000;

    // Testbench bookkeeping.
    tape_item_t  tape_q[$];
    pulse_t      pulse_q[$];
    tape_item_t  acc_item;
    logic        acc_valid  = 1'b0;
    logic        drained    = 1'b1;
    logic        drv_idle   = 1'b1;
    bit          steady_run = 1'b0;
    int          mismatch_count = 0;
    int          desc_seen      = 0;
    int          stall_cycles   = 0;

    // Predictor state: a private copy of the registers and the checksum.
    cfg_t        model_cfg;
    logic [15:0] ones_total;

    cassette_pulse_block_encoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .data_byte    (data_byte),
        .empty        (empty),
        .pop          (pop),
        .high_samples (high_samples),
        .low_samples  (low_samples),
        .repeat_res   (repeat_res),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    // Append one descriptor of the chosen pulse shape to the expected store.
    task automatic add_pulse(input bit is_long, input logic [15:0] rep, input bit fin);
        pulse_t p;
        p.high_s    = is_long ? model_cfg.long_high : model_cfg.short_high;
        p.low_s     = is_long ? model_cfg.long_low : model_cfg.short_low;
        p.rep       = rep;
        p.last_flag = fin;
        pulse_q.push_back(p);
    endtask

    // Eight bit pulses, most significant first, and then the long stop pulse.
    task automatic add_byte(input logic [7:0] b, input bit fin);
        for (int i = 7; i >= 0; i--)
        begin
            add_pulse(b[i], ONE_PULSE, 1'b0);
        end
        add_pulse(1'b1, ONE_PULSE, fin);
    endtask

    // Work out every descriptor that one accepted transaction causes.
    task automatic encode_item(input tape_item_t it);
        case (it.op)
            OP_START:
            begin
                ones_total = 16'h0000;
                add_pulse(1'b0, model_cfg.gap_pulses, 1'b0);
                add_pulse(1'b1, {8'h00, model_cfg.mark_long}, 1'b0);
                add_pulse(1'b0, {8'h00, model_cfg.mark_short}, 1'b0);
                add_pulse(1'b1, PAIR_COUNT, 1'b1);
            end
            OP_DATA:
            begin
                ones_total = ones_total + 16'($countones(it.data_val));
                add_byte(it.data_val, 1'b1);
            end
            OP_END:
            begin
                add_byte(ones_total[15:8], 1'b0);
                add_byte(ones_total[7:0], 1'b0);
                add_pulse(1'b1, PAIR_COUNT, 1'b1);
            end
            default:
            begin
                // The unused code causes nothing and keeps the checksum.
            end
        endcase
    endtask

    // Input driver: presents the head of the pending queue and holds it until taken.
    always @(posedge clk)
    begin : drive_items
        bit taken;
        bit go;
        if (!rst_n)
        begin
            push      <= 1'b0;
            acc_valid <= 1'b0;
            drv_idle  <= 1'b1;
        end
        else
        begin
            taken = push && !full;
            if (taken)
            begin
                acc_item <= tape_q.pop_front();
            end
            acc_valid <= taken;
            if (push && !taken)
            begin
                drv_idle <= 1'b0;
            end
            else
            begin
                go = (tape_q.size() != 0) &&
                     (steady_run || $urandom_range(99) >= IDLE_PCT);
                // A draining transaction waits until every descriptor has come back.
                if (go && tape_q[0].drain)
                begin
                    go = drained && !acc_valid && !taken;
                end
                if (go)
                begin
                    push      <= 1'b1;
                    operation <= tape_q[0].op;
                    data_byte <= tape_q[0].data_val;
                end
                else
                begin
                    push <= 1'b0;
                end
                drv_idle <= !go && (tape_q.size() == 0);
            end
        end
    end

    // Result monitor: predicts the transaction taken last cycle, then checks the descriptor.
    always @(posedge clk)
    begin : watch_pulses
        pulse_t want;
        if (!rst_n)
        begin
            pop     <= 1'b0;
            drained <= 1'b1;
        end
        else
        begin
            if (acc_valid)
            begin
                encode_item(acc_item);
            end
            if (pop && !empty)
            begin
                if (pulse_q.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "descriptor %0d unexpected: high %0d low %0d repeat %0d last %0b",
                        desc_seen, high_samples, low_samples, repeat_res, last));
                end
                else
                begin
                    want = pulse_q.pop_front();
                    if (high_samples !== want.high_s)
                        report_mismatch($sformatf("descriptor %0d: high_samples %0d, expected %0d",
                            desc_seen, high_samples, want.high_s));
                    if (low_samples !== want.low_s)
                        report_mismatch($sformatf("descriptor %0d: low_samples %0d, expected %0d",
                            desc_seen, low_samples, want.low_s));
                    if (repeat_res !== want.rep)
                        report_mismatch($sformatf("descriptor %0d: repeat_res %0d, expected %0d",
                            desc_seen, repeat_res, want.rep));
                    if (last !== want.last_flag)
                        report_mismatch($sformatf("descriptor %0d: last %0b, expected %0b",
                            desc_seen, last, want.last_flag));
                end
                desc_seen++;
            end
            pop     <= steady_run || ($urandom_range(99) >= IDLE_PCT);
            drained <= (pulse_q.size() == 0);
        end
    end

    // Watchdog: ends the run if no transaction moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || cfg_we)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Queue one input transaction for the driver.
    task automatic queue_item(input op_code_t op, input logic [7:0] val, input bit drain);
        tape_item_t it;
        it.op       = op;
        it.data_val = val;
        it.drain    = drain;
        tape_q.push_back(it);
    endtask

    // Mostly whole blocks with random content, the rest stray or ignored transactions.
    task automatic queue_random(input int count);
        int         made;
        int         n;
        logic [1:0] rop;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                n = $urandom_range(1, 8);
                queue_item(OP_START, 8'($urandom), $urandom_range(19) == 0);
                repeat (n)
                begin
                    queue_item(OP_DATA, 8'($urandom), $urandom_range(19) == 0);
                end
                queue_item(OP_END, 8'($urandom), $urandom_range(19) == 0);
                made += n + 2;
            end
            else
            begin
                rop = 2'($urandom_range(3));
                queue_item(op_code_t'(rop), 8'($urandom), 1'b0);
                if (rop != OP_UNUSED)
                begin
                    made++;
                end
            end
        end
    endtask

    // Register write; the block is idle whenever this is called.
    task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LONG_HIGH:  model_cfg.long_high  = val;
            REG_LONG_LOW:   model_cfg.long_low   = val;
            REG_SHORT_HIGH: model_cfg.short_high = val;
            REG_SHORT_LOW:  model_cfg.short_low  = val;
            REG_GAP:        model_cfg.gap_pulses = val;
            REG_MARK_LONG:  model_cfg.mark_long  = val[7:0];
            REG_MARK_SHORT: model_cfg.mark_short = val[7:0];
            default:        ;
        endcase
    endtask

    task automatic load_all(input logic [15:0] lh, input logic [15:0] ll,
                            input logic [15:0] sh, input logic [15:0] sl,
                            input logic [15:0] gap, input logic [15:0] ml,
                            input logic [15:0] ms);
        set_reg(REG_LONG_HIGH, lh);
        set_reg(REG_LONG_LOW, ll);
        set_reg(REG_SHORT_HIGH, sh);
        set_reg(REG_SHORT_LOW, sl);
        set_reg(REG_GAP, gap);
        set_reg(REG_MARK_LONG, ml);
        set_reg(REG_MARK_SHORT, ms);
    endtask

    // Wait until every queued transaction is taken and every descriptor has arrived.
    task automatic wait_quiet();
        repeat (2) @(posedge clk);
        while (!(drv_idle && drained && !acc_valid && !push))
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Test sequence.
    initial
    begin
        model_cfg.long_high  = RST_LONG_HIGH;
        model_cfg.long_low   = RST_LONG_LOW;
        model_cfg.short_high = RST_SHORT_HIGH;
        model_cfg.short_low  = RST_SHORT_LOW;
        model_cfg.gap_pulses = RST_GAP;
        model_cfg.mark_long  = RST_MARK_LONG;
        model_cfg.mark_short = RST_MARK_SHORT;
        ones_total           = 16'h0000;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings: data and end before any start,
        // ignored bytes, the unused code and an end that leaves the checksum.
        @(negedge clk);
        queue_item(OP_DATA, 8'hFF, 1'b0);
        queue_item(OP_DATA, 8'h00, 1'b0);
        queue_item(OP_END, 8'h3C, 1'b0);
        queue_item(OP_UNUSED, 8'h5A, 1'b0);
        queue_item(OP_START, 8'hA5, 1'b0);
        queue_item(OP_DATA, 8'h80, 1'b0);
        queue_item(OP_DATA, 8'h01, 1'b0);
        queue_item(OP_DATA, 8'h55, 1'b0);
        queue_item(OP_DATA, 8'hAA, 1'b0);
        queue_item(OP_DATA, 8'h7F, 1'b0);
        queue_item(OP_END, 8'hFF, 1'b0);
        queue_item(OP_END, 8'h00, 1'b0);
        queue_item(OP_UNUSED, 8'hA5, 1'b0);
        queue_item(OP_START, 8'h00, 1'b1);
        queue_item(OP_DATA, 8'hFE, 1'b0);
        queue_item(OP_END, 8'h81, 1'b0);
        wait_quiet();

        // Every register at its top value; the spare index must be ignored.
        load_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_reg(REG_NONE, 16'h1234);
        @(negedge clk);
        queue_item(OP_START, 8'hFF, 1'b0);
        queue_item(OP_DATA, 8'hFF, 1'b0);
        queue_item(OP_DATA, 8'h00, 1'b0);
        queue_item(OP_END, 8'h00, 1'b0);
        queue_random(50);
        wait_quiet();

        // Zero registers are used as written.
        load_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        @(negedge clk);
        queue_random(50);
        wait_quiet();

        // Smallest meaningful settings.
        load_all(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
        @(negedge clk);
        queue_random(50);
        wait_quiet();

        // Random settings with both sides running flat out.
        load_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
        @(negedge clk);
        steady_run = 1'b1;
        queue_random(60);
        wait_quiet();
        @(negedge clk);
        steady_run = 1'b0;

        // Random settings again, with the spare index written once more.
        load_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
        set_reg(REG_NONE, 16'($urandom));
        @(negedge clk);
        queue_random(60);
        wait_quiet();

        // Back to the defaults; a long block of full bytes lifts the checksum high byte.
        load_all(RST_LONG_HIGH, RST_LONG_LOW, RST_SHORT_HIGH, RST_SHORT_LOW, RST_GAP,
                 {8'h00, RST_MARK_LONG}, {8'h00, RST_MARK_SHORT});
        @(negedge clk);
        queue_item(OP_START, 8'h00, 1'b0);
        repeat (40)
        begin
            queue_item(OP_DATA, 8'hFF, 1'b0);
        end
        queue_item(OP_END, 8'h00, 1'b0);
        queue_random(30);
        wait_quiet();

        if (pulse_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected descriptors never arrived", pulse_q.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[cassette_pulse_block_encoder_unit.f]
sv/cpbe_pkg.sv
sv/cpbe_cfg_regs.sv
sv/cpbe_front.sv
sv/cpbe_cmd_fifo.sv
sv/cpbe_back.sv
sv/cassette_pulse_block_encoder_unit.sv
tb/cassette_pulse_block_encoder_unit_tb.sv
